FILE: rtl/core/qtok_pkg.sv
package qtok_pkg;

    localparam int OFF_W    = 17;
    localparam int END_W    = 18;
    localparam int COL_W    = 17;
    localparam int KW_MAX   = 10;
    localparam int WL_W     = 5;
    localparam int NRES     = 4;
    localparam int CNT_W    = 3;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int NKW      = 40;

    localparam logic [OFF_W-1:0] MAX_QUERY_LEN     = 17'd65536;
    localparam logic [COL_W-1:0] COL_SAT           = 17'd65537;
    localparam logic [7:0]       MAX_COMMENT_DEPTH = 8'd255;

    typedef enum logic [6:0] {
        C_LPAREN, C_RPAREN, C_LBRACKET, C_RBRACKET, C_LBRACE, C_RBRACE, C_COLON,
        C_COMMA, C_DOT, C_PIPE, C_PLUS, C_MODULO, C_POWER, C_STAR, C_ARROW,
        C_DASH, C_LARROW, C_LE, C_NE, C_LT, C_GE, C_GT, C_EQ, C_DIV,
        C_STRING, C_INTEGER, C_FLOAT, C_NULL, C_TRUE, C_FALSE,
        C_MATCH, C_WHERE, C_RETURN, C_CREATE, C_DELETE, C_SET, C_WITH, C_ORDER,
        C_BY, C_LIMIT, C_SKIP, C_AND, C_OR, C_NOT, C_XOR, C_COUNT, C_SUM, C_AVG,
        C_MIN, C_MAX, C_COLLECT, C_TYPE, C_ID, C_PROPERTIES, C_KEYS, C_EXISTS,
        C_SIZE, C_ASC, C_DESC, C_AS, C_IS, C_CONTAINS, C_STARTS, C_ENDS, C_IN,
        C_IDENT, C_END, C_ERROR
    } tok_cls_t;

    typedef enum logic [2:0] {
        E_NONE, E_BADCHAR, E_OPENSTR, E_OPENESC, E_BADESC, E_EXPDIG
    } err_t;

    typedef enum logic [4:0] {
        M_IDLE, M_MINUS, M_LT, M_GT, M_BANG, M_SLASH, M_LINECOM, M_BLOCK,
        M_BSTAR, M_BSLASH, M_STR, M_STR_ESC, M_INT, M_INT_DOT, M_FRAC, M_EXP,
        M_EXP_SIGN, M_EXP_DIG, M_WORD, M_CWS
    } mode_t;

    typedef struct packed {
        logic [2:0]  err;
        logic [15:0] col;
        logic [15:0] line;
        logic [15:0] span;
        logic [15:0] off;
        logic [6:0]  cls;
    } tok_t;

    typedef struct packed {
        tok_t [NRES-1:0]  rec;
        logic [CNT_W-1:0] cnt;
    } bundle_t;

    typedef struct packed {
        logic [79:0]     text;
        logic [WL_W-1:0] len;
        tok_cls_t        cls;
    } kw_t;

    localparam kw_t KW_TABLE [NKW] = '{
        '{"MATCH", 5'd5, C_MATCH}, '{"WHERE", 5'd5, C_WHERE},
        '{"RETURN", 5'd6, C_RETURN}, '{"CREATE", 5'd6, C_CREATE},
        '{"DELETE", 5'd6, C_DELETE}, '{"SET", 5'd3, C_SET},
        '{"WITH", 5'd4, C_WITH}, '{"ORDER", 5'd5, C_ORDER},
        '{"BY", 5'd2, C_BY}, '{"LIMIT", 5'd5, C_LIMIT},
        '{"SKIP", 5'd4, C_SKIP}, '{"AND", 5'd3, C_AND},
        '{"OR", 5'd2, C_OR}, '{"NOT", 5'd3, C_NOT},
        '{"XOR", 5'd3, C_XOR}, '{"COUNT", 5'd5, C_COUNT},
        '{"SUM", 5'd3, C_SUM}, '{"AVG", 5'd3, C_AVG},
        '{"MIN", 5'd3, C_MIN}, '{"MAX", 5'd3, C_MAX},
        '{"COLLECT", 5'd7, C_COLLECT}, '{"TYPE", 5'd4, C_TYPE},
        '{"ID", 5'd2, C_ID}, '{"PROPERTIES", 5'd10, C_PROPERTIES},
        '{"KEYS", 5'd4, C_KEYS}, '{"EXISTS", 5'd6, C_EXISTS},
        '{"SIZE", 5'd4, C_SIZE}, '{"ASC", 5'd3, C_ASC},
        '{"DESC", 5'd4, C_DESC}, '{"ASCENDING", 5'd9, C_ASC},
        '{"DESCENDING", 5'd10, C_DESC}, '{"AS", 5'd2, C_AS},
        '{"IS", 5'd2, C_IS}, '{"NULL", 5'd4, C_NULL},
        '{"TRUE", 5'd4, C_TRUE}, '{"FALSE", 5'd5, C_FALSE},
        '{"CONTAINS", 5'd8, C_CONTAINS}, '{"STARTS", 5'd6, C_STARTS},
        '{"ENDS", 5'd4, C_ENDS}, '{"IN", 5'd2, C_IN}
    };

    localparam logic [79:0] WITH_TEXT = "WITH";

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_wordc(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a;
    endfunction

    function automatic logic [7:0] to_up(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // text literals sit right-aligned: character i of an n-long word is byte n-1-i
    function automatic logic text_match(input logic [KW_MAX-1:0][7:0] wb,
                                        input logic [WL_W-1:0] n,
                                        input logic [79:0] text,
                                        input logic [WL_W-1:0] tlen);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < KW_MAX; i++) begin
            if (i < n && i < tlen) begin
                if (wb[i] != text[8*(tlen-1-i) +: 8]) ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic tok_cls_t kw_class(input logic [KW_MAX-1:0][7:0] wb,
                                          input logic [WL_W-1:0] n);
        tok_cls_t r;
        r = C_IDENT;
        for (int k = NKW - 1; k >= 0; k--) begin
            if (KW_TABLE[k].len == n &&
                text_match(wb, n, KW_TABLE[k].text, KW_TABLE[k].len)) begin
                r = KW_TABLE[k].cls;
            end
        end
        return r;
    endfunction

    function automatic logic with_prefix(input logic [KW_MAX-1:0][7:0] wb,
                                         input logic [WL_W-1:0] n);
        return n <= 5'd4 && text_match(wb, n, WITH_TEXT, 5'd4);
    endfunction

    function automatic logic [15:0] sat16(input logic [END_W-1:0] v);
        return (v > 18'd65535) ? 16'hffff : v[15:0];
    endfunction

    function automatic tok_t make_rec(input tok_cls_t cls, input err_t err,
                                      input logic [OFF_W-1:0] so,
                                      input logic [15:0] sl,
                                      input logic [COL_W-1:0] sc,
                                      input logic [END_W-1:0] e);
        tok_t r;
        logic [END_W-1:0] so_x;
        so_x = {1'b0, so};
        r.cls  = cls;
        r.err  = err;
        r.off  = sat16(so_x);
        r.span = sat16((e >= so_x) ? e - so_x : '0);
        r.line = sl;
        r.col  = sat16({1'b0, sc});
        return r;
    endfunction

endpackage

FILE: rtl/core/qtok_scan.sv
module qtok_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        ch,
    input  logic              final_char,
    input  logic              q_full,
    output logic              push,
    output qtok_pkg::bundle_t push_data
);
    import qtok_pkg::*;

    mode_t                   mode_reg, mode_next;
    logic [OFF_W-1:0]        off_reg, off_next;
    logic [15:0]             line_reg, line_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [OFF_W-1:0]        soff_reg, soff_next;
    logic [15:0]             sline_reg, sline_next;
    logic [COL_W-1:0]        scol_reg, scol_next;
    logic [KW_MAX-1:0][7:0]  wb_reg, wb_next;
    logic [WL_W-1:0]         wl_reg, wl_next;
    logic [7:0]              depth_reg, depth_next;
    logic                    oq_reg, oq_next;
    logic                    pv_reg, pv_next;
    tok_cls_t                pcls_reg, pcls_next;
    logic [OFF_W-1:0]        poff_reg, poff_next;
    logic [15:0]             pline_reg, pline_next;
    logic [COL_W-1:0]        pcol_reg, pcol_next;
    logic                    stop_reg, stop_next;

    tok_t [NRES-1:0]         rec;
    logic [CNT_W-1:0]        n;
    logic                    accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic go_idle, go_cws, done;
        logic [OFF_W-1:0] co;
        logic [15:0] cl;
        logic [COL_W-1:0] cc;
        logic [END_W-1:0] e0, e1, pend_end, dot_x;
        logic [OFF_W-1:0] dot;
        logic [COL_W-1:0] dcol;
        tok_cls_t kc;

        mode_next  = mode_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        soff_next  = soff_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        wb_next    = wb_reg;
        wl_next    = wl_reg;
        depth_next = depth_reg;
        oq_next    = oq_reg;
        pv_next    = pv_reg;
        pcls_next  = pcls_reg;
        poff_next  = poff_reg;
        pline_next = pline_reg;
        pcol_next  = pcol_reg;
        stop_next  = stop_reg;
        rec        = '0;
        n          = '0;
        go_idle    = 1'b0;
        go_cws     = 1'b0;
        done       = 1'b0;
        co         = off_reg;
        cl         = line_reg;
        cc         = col_reg;
        e0         = {1'b0, co};
        e1         = e0 + 18'd1;
        pend_end   = '0;
        dot        = '0;
        dot_x      = '0;
        dcol       = '0;
        kc         = C_IDENT;

        if (accept) begin
            if (!stop_reg) begin
                case (mode_reg)
                    M_MINUS:
                    begin
                        if (ch == ">") begin
                            rec[n[1:0]] = make_rec(C_ARROW, E_NONE, soff_next, sline_next,
                                                   scol_next, e1);
                            n = n + 3'd1;
                            mode_next = M_IDLE;
                        end else if (ch == "-") begin
                            mode_next = M_LINECOM;
                        end else if (is_digit(ch)) begin
                            mode_next = M_INT;
                        end else begin
                            rec[n[1:0]] = make_rec(C_DASH, E_NONE, soff_next, sline_next,
                                                   scol_next, e0);
                            n = n + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_LT:
                    begin
                        if (ch == "-" || ch == "=" || ch == ">") begin
                            rec[n[1:0]] = make_rec((ch == "-") ? C_LARROW :
                                                   (ch == "=") ? C_LE : C_NE, E_NONE,
                                                   soff_next, sline_next, scol_next, e1);
                            n = n + 3'd1;
                            mode_next = M_IDLE;
                        end else begin
                            rec[n[1:0]] = make_rec(C_LT, E_NONE, soff_next, sline_next,
                                                   scol_next, e0);
                            n = n + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_GT:
                    begin
                        if (ch == "=") begin
                            rec[n[1:0]] = make_rec(C_GE, E_NONE, soff_next, sline_next,
                                                   scol_next, e1);
                            n = n + 3'd1;
                            mode_next = M_IDLE;
                        end else begin
                            rec[n[1:0]] = make_rec(C_GT, E_NONE, soff_next, sline_next,
                                                   scol_next, e0);
                            n = n + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_BANG:
                    begin
                        if (ch == "=") begin
                            rec[n[1:0]] = make_rec(C_NE, E_NONE, soff_next, sline_next,
                                                   scol_next, e1);
                        end else begin
                            rec[n[1:0]] = make_rec(C_ERROR, E_BADCHAR, soff_next, sline_next,
                                                   scol_next, e0);
                            stop_next = 1'b1;
                        end
                        n = n + 3'd1;
                        mode_next = M_IDLE;
                    end
                    M_SLASH:
                    begin
                        if (ch == "/") begin
                            mode_next = M_LINECOM;
                        end else if (ch == "*") begin
                            depth_next = 8'd1;
                            mode_next = M_BLOCK;
                        end else begin
                            rec[n[1:0]] = make_rec(C_DIV, E_NONE, soff_next, sline_next,
                                                   scol_next, e0);
                            n = n + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_LINECOM:
                    begin
                        if (ch == 8'h0a) mode_next = M_IDLE;
                    end
                    M_BLOCK, M_BSTAR, M_BSLASH:
                    begin
                        if (mode_reg == M_BSTAR && ch == "/") begin
                            if (depth_next > 8'd0) depth_next = depth_next - 8'd1;
                            mode_next = (depth_next != 8'd0) ? M_BLOCK : M_IDLE;
                        end else if (mode_reg == M_BSLASH && ch == "*") begin
                            if (depth_next < MAX_COMMENT_DEPTH) depth_next = depth_next + 8'd1;
                            mode_next = M_BLOCK;
                        end else begin
                            mode_next = (ch == "*") ? M_BSTAR : (ch == "/") ? M_BSLASH : M_BLOCK;
                        end
                    end
                    M_STR:
                    begin
                        if (ch == (oq_reg ? 8'h27 : 8'h22)) begin
                            rec[n[1:0]] = make_rec(C_STRING, E_NONE, soff_next, sline_next,
                                                   scol_next, e1);
                            n = n + 3'd1;
                            mode_next = M_IDLE;
                        end else if (ch == 8'h0a) begin
                            rec[n[1:0]] = make_rec(C_ERROR, E_OPENSTR, soff_next, sline_next,
                                                   scol_next, e0);
                            n = n + 3'd1;
                            stop_next = 1'b1;
                            mode_next = M_IDLE;
                        end else if (ch == 8'h5c) begin
                            mode_next = M_STR_ESC;
                        end
                    end
                    M_STR_ESC:
                    begin
                        if (ch == "n" || ch == "t" || ch == "r" || ch == 8'h5c ||
                            ch == 8'h22 || ch == 8'h27) begin
                            mode_next = M_STR;
                        end else begin
                            rec[n[1:0]] = make_rec(C_ERROR, E_BADESC, soff_next, sline_next,
                                                   scol_next, e1);
                            n = n + 3'd1;
                            stop_next = 1'b1;
                            mode_next = M_IDLE;
                        end
                    end
                    M_INT, M_FRAC:
                    begin
                        if (!is_digit(ch)) begin
                            if (ch == "." && mode_reg == M_INT) begin
                                mode_next = M_INT_DOT;
                            end else if (ch == "e" || ch == "E") begin
                                mode_next = M_EXP;
                            end else begin
                                rec[n[1:0]] = make_rec((mode_reg == M_INT) ? C_INTEGER : C_FLOAT,
                                                       E_NONE, soff_next, sline_next,
                                                       scol_next, e0);
                                n = n + 3'd1;
                                go_idle = 1'b1;
                            end
                        end
                    end
                    M_INT_DOT:
                    begin
                        if (is_digit(ch)) begin
                            mode_next = M_FRAC;
                        end else begin
                            dot = (co > '0) ? co - 17'd1 : '0;
                            dot_x = {1'b0, dot};
                            dcol = (cc > 17'd1) ? cc - 17'd1 : 17'd1;
                            rec[n[1:0]] = make_rec(C_INTEGER, E_NONE, soff_next, sline_next,
                                                   scol_next, dot_x);
                            n = n + 3'd1;
                            rec[n[1:0]] = make_rec(C_DOT, E_NONE, dot, cl, dcol, e0);
                            n = n + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_EXP, M_EXP_SIGN:
                    begin
                        if (mode_reg == M_EXP && (ch == "+" || ch == "-")) begin
                            mode_next = M_EXP_SIGN;
                        end else if (is_digit(ch)) begin
                            mode_next = M_EXP_DIG;
                        end else begin
                            rec[n[1:0]] = make_rec(C_ERROR, E_EXPDIG, soff_next, sline_next,
                                                   scol_next, e0);
                            n = n + 3'd1;
                            stop_next = 1'b1;
                            mode_next = M_IDLE;
                        end
                    end
                    M_EXP_DIG:
                    begin
                        if (!is_digit(ch)) begin
                            rec[n[1:0]] = make_rec(C_FLOAT, E_NONE, soff_next, sline_next,
                                                   scol_next, e0);
                            n = n + 3'd1;
                            go_idle = 1'b1;
                        end
                    end
                    M_WORD:
                    begin
                        if (pv_next && !is_alpha(ch)) begin
                            if (wl_next == 5'd4 && with_prefix(wb_next, wl_next)) begin
                                rec[n[1:0]] = make_rec(pcls_next, E_NONE, poff_next,
                                                       pline_next, pcol_next, e0);
                                n = n + 3'd1;
                                pv_next = 1'b0;
                                go_idle = 1'b1;
                                done = 1'b1;
                            end else begin
                                pend_end = {1'b0, poff_next} +
                                           ((pcls_next == C_STARTS) ? 18'd6 : 18'd4);
                                rec[n[1:0]] = make_rec(pcls_next, E_NONE, poff_next,
                                                       pline_next, pcol_next, pend_end);
                                n = n + 3'd1;
                                pv_next = 1'b0;
                            end
                        end
                        if (!done) begin
                            if (is_wordc(ch)) begin
                                if (wl_next < KW_MAX[WL_W-1:0])
                                    wb_next[wl_next[3:0]] = to_up(ch);
                                if (wl_next <= KW_MAX[WL_W-1:0]) wl_next = wl_next + 5'd1;
                                if (pv_next && !with_prefix(wb_next, wl_next)) begin
                                    pend_end = {1'b0, poff_next} +
                                               ((pcls_next == C_STARTS) ? 18'd6 : 18'd4);
                                    rec[n[1:0]] = make_rec(pcls_next, E_NONE, poff_next,
                                                           pline_next, pcol_next, pend_end);
                                    n = n + 3'd1;
                                    pv_next = 1'b0;
                                end
                            end else begin
                                kc = (wl_next > KW_MAX[WL_W-1:0]) ? C_IDENT :
                                     kw_class(wb_next, wl_next);
                                if (kc == C_STARTS || kc == C_ENDS) begin
                                    pv_next    = 1'b1;
                                    pcls_next  = kc;
                                    poff_next  = soff_next;
                                    pline_next = sline_next;
                                    pcol_next  = scol_next;
                                    mode_next  = M_CWS;
                                    go_cws     = 1'b1;
                                end else begin
                                    rec[n[1:0]] = make_rec(kc, E_NONE, soff_next, sline_next,
                                                           scol_next, e0);
                                    n = n + 3'd1;
                                    go_idle = 1'b1;
                                end
                            end
                        end
                    end
                    M_CWS:
                    begin
                        go_cws = 1'b1;
                    end
                    default:
                    begin
                        go_idle = 1'b1;
                    end
                endcase

                if (go_cws && !is_ws(ch)) begin
                    if (to_up(ch) == "W") begin
                        soff_next  = co;
                        sline_next = cl;
                        scol_next  = cc;
                        wb_next[0] = to_up(ch);
                        wl_next    = 5'd1;
                        mode_next  = M_WORD;
                    end else begin
                        pend_end = {1'b0, poff_next} +
                                   ((pcls_next == C_STARTS) ? 18'd6 : 18'd4);
                        rec[n[1:0]] = make_rec(pcls_next, E_NONE, poff_next, pline_next,
                                               pcol_next, pend_end);
                        n = n + 3'd1;
                        pv_next = 1'b0;
                        go_idle = 1'b1;
                    end
                end

                if (go_idle) begin
                    mode_next = M_IDLE;
                    if (!is_ws(ch)) begin
                        soff_next  = co;
                        sline_next = cl;
                        scol_next  = cc;
                        case (ch)
                            "(", ")", "[", "]", "{", "}", ":", ",", ".", "|", "+", "%",
                            "^", "*", "=":
                            begin
                                case (ch)
                                    "(": kc = C_LPAREN;
                                    ")": kc = C_RPAREN;
                                    "[": kc = C_LBRACKET;
                                    "]": kc = C_RBRACKET;
                                    "{": kc = C_LBRACE;
                                    "}": kc = C_RBRACE;
                                    ":": kc = C_COLON;
                                    ",": kc = C_COMMA;
                                    ".": kc = C_DOT;
                                    "|": kc = C_PIPE;
                                    "+": kc = C_PLUS;
                                    "%": kc = C_MODULO;
                                    "^": kc = C_POWER;
                                    "*": kc = C_STAR;
                                    default: kc = C_EQ;
                                endcase
                                if (n < 3'd4) begin
                                    rec[n[1:0]] = make_rec(kc, E_NONE, co, cl, cc, e1);
                                    n = n + 3'd1;
                                end
                            end
                            "-": mode_next = M_MINUS;
                            "<": mode_next = M_LT;
                            ">": mode_next = M_GT;
                            "!": mode_next = M_BANG;
                            "/": mode_next = M_SLASH;
                            8'h22:
                            begin
                                oq_next = 1'b0;
                                mode_next = M_STR;
                            end
                            8'h27:
                            begin
                                oq_next = 1'b1;
                                mode_next = M_STR;
                            end
                            default:
                            begin
                                if (is_digit(ch)) begin
                                    mode_next = M_INT;
                                end else if (is_alpha(ch) || ch == "_") begin
                                    wb_next[0] = to_up(ch);
                                    wl_next = 5'd1;
                                    mode_next = M_WORD;
                                end else begin
                                    if (n < 3'd4) begin
                                        rec[n[1:0]] = make_rec(C_ERROR, E_BADCHAR, co, cl,
                                                               cc, e1);
                                        n = n + 3'd1;
                                    end
                                    stop_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end

            if (off_reg < MAX_QUERY_LEN) off_next = off_reg + 17'd1;
            if (ch == 8'h0a) begin
                if (line_reg != 16'hffff) line_next = line_reg + 16'd1;
                col_next = 17'd1;
            end else if (col_reg < COL_SAT) begin
                col_next = col_reg + 17'd1;
            end

            if (final_char) begin
                co = off_next;
                cl = line_next;
                cc = col_next;
                e0 = {1'b0, co};
                if (!stop_next) begin
                    case (mode_next)
                        M_MINUS, M_LT, M_GT, M_SLASH, M_INT, M_FRAC, M_EXP_DIG:
                        begin
                            case (mode_next)
                                M_MINUS: kc = C_DASH;
                                M_LT:    kc = C_LT;
                                M_GT:    kc = C_GT;
                                M_SLASH: kc = C_DIV;
                                M_INT:   kc = C_INTEGER;
                                default: kc = C_FLOAT;
                            endcase
                            if (n < 3'd4) begin
                                rec[n[1:0]] = make_rec(kc, E_NONE, soff_next, sline_next,
                                                       scol_next, e0);
                                n = n + 3'd1;
                            end
                        end
                        M_BANG, M_STR, M_STR_ESC, M_EXP, M_EXP_SIGN:
                        begin
                            if (n < 3'd4) begin
                                rec[n[1:0]] = make_rec(C_ERROR,
                                    (mode_next == M_BANG) ? E_BADCHAR :
                                    (mode_next == M_STR) ? E_OPENSTR :
                                    (mode_next == M_STR_ESC) ? E_OPENESC : E_EXPDIG,
                                    soff_next, sline_next, scol_next, e0);
                                n = n + 3'd1;
                            end
                        end
                        M_INT_DOT:
                        begin
                            dot = (co > '0) ? co - 17'd1 : '0;
                            dot_x = {1'b0, dot};
                            dcol = (cc > 17'd1) ? cc - 17'd1 : 17'd1;
                            if (n < 3'd4) begin
                                rec[n[1:0]] = make_rec(C_INTEGER, E_NONE, soff_next,
                                                       sline_next, scol_next, dot_x);
                                n = n + 3'd1;
                            end
                            if (n < 3'd4) begin
                                rec[n[1:0]] = make_rec(C_DOT, E_NONE, dot, cl, dcol, e0);
                                n = n + 3'd1;
                            end
                        end
                        M_WORD:
                        begin
                            done = 1'b0;
                            if (pv_next) begin
                                if (wl_next == 5'd4 && with_prefix(wb_next, wl_next)) begin
                                    if (n < 3'd4) begin
                                        rec[n[1:0]] = make_rec(pcls_next, E_NONE, poff_next,
                                                               pline_next, pcol_next, e0);
                                        n = n + 3'd1;
                                    end
                                    done = 1'b1;
                                end else begin
                                    pend_end = {1'b0, poff_next} +
                                               ((pcls_next == C_STARTS) ? 18'd6 : 18'd4);
                                    if (n < 3'd4) begin
                                        rec[n[1:0]] = make_rec(pcls_next, E_NONE, poff_next,
                                                               pline_next, pcol_next, pend_end);
                                        n = n + 3'd1;
                                    end
                                end
                            end
                            if (!done && n < 3'd4) begin
                                kc = (wl_next > KW_MAX[WL_W-1:0]) ? C_IDENT :
                                     kw_class(wb_next, wl_next);
                                rec[n[1:0]] = make_rec(kc, E_NONE, soff_next, sline_next,
                                                       scol_next, e0);
                                n = n + 3'd1;
                            end
                        end
                        M_CWS:
                        begin
                            pend_end = {1'b0, poff_next} +
                                       ((pcls_next == C_STARTS) ? 18'd6 : 18'd4);
                            if (n < 3'd4) begin
                                rec[n[1:0]] = make_rec(pcls_next, E_NONE, poff_next,
                                                       pline_next, pcol_next, pend_end);
                                n = n + 3'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (n < 3'd4) begin
                    rec[n[1:0]] = make_rec(C_END, E_NONE, co, cl, cc, e0);
                    n = n + 3'd1;
                end

                mode_next  = M_IDLE;
                off_next   = '0;
                line_next  = 16'd1;
                col_next   = 17'd1;
                soff_next  = '0;
                sline_next = 16'd1;
                scol_next  = 17'd1;
                wl_next    = '0;
                depth_next = '0;
                oq_next    = 1'b0;
                pv_next    = 1'b0;
                pcls_next  = C_LPAREN;
                poff_next  = '0;
                pline_next = 16'd1;
                pcol_next  = 17'd1;
                stop_next  = 1'b0;
            end
        end
    end

    always_comb
    begin
        push          = accept && (n != '0);
        push_data.rec = rec;
        push_data.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            off_reg   <= '0;
            line_reg  <= 16'd1;
            col_reg   <= 17'd1;
            soff_reg  <= '0;
            sline_reg <= 16'd1;
            scol_reg  <= 17'd1;
            wl_reg    <= '0;
            depth_reg <= '0;
            oq_reg    <= 1'b0;
            pv_reg    <= 1'b0;
            pcls_reg  <= C_LPAREN;
            poff_reg  <= '0;
            pline_reg <= 16'd1;
            pcol_reg  <= 17'd1;
            stop_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            soff_reg  <= soff_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            wl_reg    <= wl_next;
            depth_reg <= depth_next;
            oq_reg    <= oq_next;
            pv_reg    <= pv_next;
            pcls_reg  <= pcls_next;
            poff_reg  <= poff_next;
            pline_reg <= pline_next;
            pcol_reg  <= pcol_next;
            stop_reg  <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg <= wb_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> mode_reg == M_IDLE)
        else $error("scanner left idle after error");
    assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> (mode_reg == M_WORD || mode_reg == M_CWS))
        else $error("compound pending outside word scan");
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_char) |=> (off_reg == '0 && !stop_reg && !pv_reg))
        else $error("state not cleared after last character");
endmodule

FILE: rtl/core/qtok_fifo.sv
module qtok_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qtok_pkg::bundle_t push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output qtok_pkg::bundle_t head
);
    import qtok_pkg::*;

    bundle_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full  = count_reg == QDEPTH[QPTR_W:0];
    assign empty = count_reg == '0;
    assign head  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wptr_reg] <= push_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> head.cnt != '0)
        else $error("queued bundle holds no transfer");
endmodule

FILE: rtl/core/qtok_drain.sv
module qtok_drain (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  qtok_pkg::bundle_t head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output qtok_pkg::tok_t    m_tok,
    output logic              m_tlast
);
    import qtok_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       fire;

    assign m_tvalid = !empty;
    assign m_tok    = head.rec[idx_reg];
    assign m_tlast  = ({1'b0, idx_reg} + 3'd1) == head.cnt;
    assign fire     = m_tvalid && m_tready;
    assign pop      = fire && m_tlast;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire) idx_next = m_tlast ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) idx_reg <= '0;
        else idx_reg <= idx_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, idx_reg} < head.cnt))
        else $error("record index past bundle count");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !m_tlast) |=> idx_reg == $past(idx_reg) + 2'd1)
        else $error("record index did not advance");
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> idx_reg == 2'd0)
        else $error("record index not rewound");
endmodule

FILE: rtl/core/query_tokenizer.sv
// A record is queued when the character that ends it is accepted and is offered
// from the queue head once registered. Input takes one character per cycle while
// the four-bundle queue is not full; each record is one transfer on the single output
// port draining that queue, so a character yielding k records makes k transfers.
// Reset: rst_n low clears scanner state, queue pointers and output index at once.
module query_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ch
    input  logic        s_axis_tlast,  // final_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // token_class, start_offset, span_length,
                                       // start_line, start_column, error_code, zero pad
    output logic        m_axis_tlast   // last_of_run
);
    import qtok_pkg::*;

    logic    q_full, q_empty, push, pop;
    bundle_t push_data, head;
    tok_t    tok;

    qtok_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .ch         (s_axis_tdata),
        .final_char (s_axis_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    qtok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .head      (head)
    );

    qtok_drain u_drain (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tok    (tok),
        .m_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, tok};
endmodule
